// ===== rtl/lrss_pkg.sv =====
// Shared types, constants and helper functions for the LED ring spinner sequencer.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package lrss_pkg;

  // Ring geometry and field widths
  localparam int LED_COUNT       = 12;
  localparam int LED_BITS        = 4;
  localparam int PERIOD_BITS     = 20;
  localparam int DEGREE_BITS     = 9;
  localparam int STEP_BITS       = 16;
  localparam int COLOUR_BITS     = 24;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 20;
  localparam int DEGREES_PER_LED = 30;

  localparam logic [LED_BITS-1:0] LED_LAST = LED_BITS'(LED_COUNT - 1);

  // Reciprocal of 30 as 17/512; underestimates the quotient by at most one
  localparam int DEG_RECIP       = 17;
  localparam int DEG_RECIP_SHIFT = 9;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_ANGLE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPIN_CLOCKWISE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TAIL_LENGTH    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE_PERIOD    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ACCEL_STEP     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PERIOD     = 3'd5;

  // Configuration reset values
  localparam logic [DEGREE_BITS-1:0] ORIGIN_ANGLE_RST   = 9'd0;
  localparam logic                   SPIN_CLOCKWISE_RST = 1'b1;
  localparam logic [LED_BITS-1:0]    TAIL_LENGTH_RST    = 4'd5;
  localparam logic [PERIOD_BITS-1:0] BASE_PERIOD_RST    = 20'd80000;
  localparam logic [STEP_BITS-1:0]   ACCEL_STEP_RST     = 16'd1000;
  localparam logic [PERIOD_BITS-1:0] MIN_PERIOD_RST     = 20'd70000;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_END   = 3'd2,
    OP_STOP  = 3'd3,
    OP_LOAD  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SPIN = 2'd1,
    PH_SEEK = 2'd2,
    PH_FADE = 2'd3
  } phase_t;

  typedef enum logic {
    CTL_READY = 1'b0,
    CTL_EMIT  = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic [DEGREE_BITS-1:0] origin_angle;
    logic                   spin_clockwise;
    logic [LED_BITS-1:0]    tail_length;
    logic [PERIOD_BITS-1:0] base_period;
    logic [STEP_BITS-1:0]   accel_step;
    logic [PERIOD_BITS-1:0] min_period;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;   // take the input transaction and update state
    logic load;   // render one LED into the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frame_req;  // presented item renders a frame
    logic out_valid;  // output register occupied
    logic pix_last;   // next LED to render is the last of the frame
  } dp_status_t;

  // LED position of an angle: (deg / 30) mod 12
  function automatic logic [LED_BITS-1:0] degree_to_led(input logic [DEGREE_BITS-1:0] deg);
    logic [13:0] prod;
    logic [4:0]  quo;
    logic [9:0]  rem;
    prod = 14'(deg) * 14'(DEG_RECIP);
    quo  = prod[13:DEG_RECIP_SHIFT];
    rem  = 10'(deg) - 10'(quo) * 10'(DEGREES_PER_LED);
    if (rem >= 10'(DEGREES_PER_LED)) begin
      quo = quo + 5'd1;
    end
    if (quo >= 5'(LED_COUNT)) begin
      quo = quo - 5'(LED_COUNT);
    end
    return quo[LED_BITS-1:0];
  endfunction

  // One step round the ring, up or down
  function automatic logic [LED_BITS-1:0] step_pos(input logic [LED_BITS-1:0] pos,
                                                   input logic up);
    logic [LED_BITS-1:0] res;
    if (up) begin
      res = (pos == LED_LAST) ? '0 : pos + 1'b1;
    end else begin
      res = (pos == '0) ? LED_LAST : pos - 1'b1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lrss_cfg_regs.sv =====
// Configuration register bank for the LED ring spinner sequencer.
// Depends on lrss_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module lrss_cfg_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [lrss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lrss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output lrss_pkg::cfg_t                           cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_angle   <= lrss_pkg::ORIGIN_ANGLE_RST;
      cfg.spin_clockwise <= lrss_pkg::SPIN_CLOCKWISE_RST;
      cfg.tail_length    <= lrss_pkg::TAIL_LENGTH_RST;
      cfg.base_period    <= lrss_pkg::BASE_PERIOD_RST;
      cfg.accel_step     <= lrss_pkg::ACCEL_STEP_RST;
      cfg.min_period     <= lrss_pkg::MIN_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lrss_pkg::CFG_ORIGIN_ANGLE:
          cfg.origin_angle <= cfg_data[lrss_pkg::DEGREE_BITS-1:0];
        lrss_pkg::CFG_SPIN_CLOCKWISE:
          cfg.spin_clockwise <= cfg_data[0];
        lrss_pkg::CFG_TAIL_LENGTH:
          cfg.tail_length <= cfg_data[lrss_pkg::LED_BITS-1:0];
        lrss_pkg::CFG_BASE_PERIOD:
          cfg.base_period <= cfg_data[lrss_pkg::PERIOD_BITS-1:0];
        lrss_pkg::CFG_ACCEL_STEP:
          cfg.accel_step <= cfg_data[lrss_pkg::STEP_BITS-1:0];
        lrss_pkg::CFG_MIN_PERIOD:
          cfg.min_period <= cfg_data[lrss_pkg::PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lrss_ctrl.sv =====
// Controller state machine: accepts a transaction and, if it yields a frame,
// sequences its twelve LED renders into the output register. Needs lrss_pkg.
`default_nettype none

module lrss_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 out_stall,
  input  wire lrss_pkg::dp_status_t status,
  output lrss_pkg::ctl_cmd_t        cmd
);

  lrss_pkg::ctl_state_t state;
  lrss_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrss_pkg::CTL_READY;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lrss_pkg::CTL_READY: begin
        if (in_valid && status.frame_req) begin
          state_next = lrss_pkg::CTL_EMIT;
        end
      end
      lrss_pkg::CTL_EMIT: begin
        if (!(status.out_valid && out_stall) && status.pix_last) begin
          state_next = lrss_pkg::CTL_READY;
        end
      end
      default: state_next = lrss_pkg::CTL_READY;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      lrss_pkg::CTL_READY: begin
        in_stall = 1'b0;
        cmd.exec = in_valid;
      end
      lrss_pkg::CTL_EMIT: begin
        cmd.load = !(status.out_valid && out_stall);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lrss_datapath.sv =====
// Datapath: comet state, tail colour store, frame setup and per-LED render
// into the output register. Driven by lrss_ctrl; depends on lrss_pkg.
`default_nettype none

module lrss_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire lrss_pkg::cfg_t                      cfg,
  input  wire lrss_pkg::ctl_cmd_t                  cmd,
  output lrss_pkg::dp_status_t                     status,
  input  wire logic [2:0]                          operation,
  input  wire logic                                end_now,
  input  wire logic [lrss_pkg::DEGREE_BITS-1:0]    target_angle,
  input  wire logic [lrss_pkg::LED_BITS-1:0]       color_index,
  input  wire logic [7:0]                          red_in,
  input  wire logic [7:0]                          green_in,
  input  wire logic [7:0]                          blue_in,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic [lrss_pkg::LED_BITS-1:0]            led_index,
  output logic [7:0]                               red_out,
  output logic [7:0]                               green_out,
  output logic [7:0]                               blue_out,
  output logic [lrss_pkg::PERIOD_BITS-1:0]         hold_period,
  output logic                                     frame_last
);

  localparam int LB = lrss_pkg::LED_BITS;
  localparam int PB = lrss_pkg::PERIOD_BITS;
  localparam int CB = lrss_pkg::COLOUR_BITS;

  // Comet state
  lrss_pkg::phase_t phase, phase_next;
  logic [LB-1:0] head_position, head_position_next;
  logic [LB-1:0] drawn_length, drawn_length_next;
  logic [PB-1:0] current_period, current_period_next;
  logic          end_pending, end_pending_next;
  logic          end_now_flag, end_now_flag_next;
  logic [LB-1:0] end_position, end_position_next;
  logic [LB-1:0] fade_step, fade_step_next;
  logic [CB-1:0] tail_colors [lrss_pkg::LED_COUNT];

  // Frame being rendered
  logic [LB-1:0] frame_head, frame_count, frame_first;
  logic [PB-1:0] frame_hold;
  logic [LB-1:0] pix_index;

  // Frame setup from the presented transaction
  logic          frame_req;
  logic [LB-1:0] fr_head, fr_count, fr_first;
  logic [PB-1:0] fr_hold;
  logic          tail_we;
  logic          seek_go, fade_go;
  logic [LB-1:0] seek_pos, fade_cur, eff_len;

  // Render of one LED
  logic [LB:0]   diff;
  logic [LB-1:0] tail_k;
  logic [LB:0]   entry;
  logic          lit;
  logic [CB-1:0] pix_colour;

  assign eff_len = (cfg.tail_length > LB'(lrss_pkg::LED_COUNT)) ?
                   LB'(lrss_pkg::LED_COUNT) : cfg.tail_length;

  // Operation decode and tick sequencing
  always_comb begin
    phase_next          = phase;
    head_position_next  = head_position;
    drawn_length_next   = drawn_length;
    current_period_next = current_period;
    end_pending_next    = end_pending;
    end_now_flag_next   = end_now_flag;
    end_position_next   = end_position;
    fade_step_next      = fade_step;
    frame_req = 1'b0;
    fr_head   = head_position;
    fr_count  = '0;
    fr_first  = '0;
    fr_hold   = '0;
    tail_we   = 1'b0;
    seek_go   = 1'b0;
    fade_go   = 1'b0;
    seek_pos  = end_position;
    fade_cur  = fade_step;

    unique case (lrss_pkg::op_t'(operation))
      lrss_pkg::OP_TICK: begin
        // Spinning: moving frame with acceleration, or resolve an end request
        if (phase == lrss_pkg::PH_SPIN) begin
          if (!end_pending) begin
            frame_req          = 1'b1;
            fr_count           = drawn_length;
            fr_hold            = current_period;
            head_position_next = lrss_pkg::step_pos(head_position, cfg.spin_clockwise);
            if (drawn_length < eff_len) begin
              drawn_length_next = drawn_length + 1'b1;
            end
            if (current_period >= cfg.min_period) begin
              if (current_period >= PB'(cfg.accel_step)) begin
                current_period_next = current_period - PB'(cfg.accel_step);
              end else begin
                current_period_next = '0;
              end
            end
          end else begin
            if (end_now_flag) begin
              seek_pos = head_position;
            end
            end_position_next = seek_pos;
            end_pending_next  = 1'b0;
            phase_next        = lrss_pkg::PH_SEEK;
            seek_go           = 1'b1;
          end
        end
        // Seeking the end position at the base period
        if (phase == lrss_pkg::PH_SEEK || seek_go) begin
          if (head_position != seek_pos) begin
            frame_req          = 1'b1;
            fr_count           = drawn_length;
            fr_hold            = cfg.base_period;
            head_position_next = lrss_pkg::step_pos(head_position, cfg.spin_clockwise);
            if (drawn_length < eff_len) begin
              drawn_length_next = drawn_length + 1'b1;
            end
          end else begin
            phase_next     = lrss_pkg::PH_FADE;
            fade_step_next = '0;
            fade_cur       = '0;
            fade_go        = 1'b1;
          end
        end
        // Fading the tail behind the last drawn head
        if (phase == lrss_pkg::PH_FADE || fade_go) begin
          if (fade_cur >= eff_len) begin
            phase_next = lrss_pkg::PH_IDLE;
          end else begin
            frame_req      = 1'b1;
            fr_head        = lrss_pkg::step_pos(head_position, !cfg.spin_clockwise);
            fr_count       = eff_len - fade_cur - 1'b1;
            fr_first       = fade_cur + 1'b1;
            fr_hold        = cfg.base_period;
            fade_step_next = fade_cur + 1'b1;
            if (fade_cur + 1'b1 >= eff_len) begin
              phase_next = lrss_pkg::PH_IDLE;
            end
          end
        end
      end
      lrss_pkg::OP_START: begin
        phase_next          = lrss_pkg::PH_SPIN;
        head_position_next  = lrss_pkg::degree_to_led(cfg.origin_angle);
        drawn_length_next   = '0;
        current_period_next = cfg.base_period;
        end_pending_next    = 1'b0;
        end_now_flag_next   = 1'b0;
        fade_step_next      = '0;
      end
      lrss_pkg::OP_END: begin
        if (phase == lrss_pkg::PH_SPIN) begin
          end_pending_next  = 1'b1;
          end_now_flag_next = end_now;
          end_position_next = lrss_pkg::degree_to_led(target_angle);
        end
      end
      lrss_pkg::OP_STOP: begin
        // Blank frame, zero hold
        phase_next       = lrss_pkg::PH_IDLE;
        end_pending_next = 1'b0;
        frame_req        = 1'b1;
      end
      lrss_pkg::OP_LOAD: begin
        tail_we = (color_index < LB'(lrss_pkg::LED_COUNT));
      end
      default: ;
    endcase
  end

  // State and frame setup registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= lrss_pkg::PH_IDLE;
      head_position  <= '0;
      drawn_length   <= '0;
      current_period <= '0;
      end_pending    <= 1'b0;
      end_now_flag   <= 1'b0;
      end_position   <= '0;
      fade_step      <= '0;
    end else if (cmd.exec) begin
      phase          <= phase_next;
      head_position  <= head_position_next;
      drawn_length   <= drawn_length_next;
      current_period <= current_period_next;
      end_pending    <= end_pending_next;
      end_now_flag   <= end_now_flag_next;
      end_position   <= end_position_next;
      fade_step      <= fade_step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      frame_head  <= fr_head;
      frame_count <= fr_count;
      frame_first <= fr_first;
      frame_hold  <= fr_hold;
    end
  end

  // Tail colour store, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lrss_pkg::LED_COUNT; i++) begin
        tail_colors[i] <= '0;
      end
    end else if (cmd.exec && tail_we) begin
      tail_colors[color_index] <= {red_in, green_in, blue_in};
    end
  end

  // LED counter within the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_index <= '0;
    end else if (cmd.exec) begin
      pix_index <= '0;
    end else if (cmd.load) begin
      pix_index <= (pix_index == lrss_pkg::LED_LAST) ? '0 : pix_index + 1'b1;
    end
  end

  // Tail entry lighting the current LED
  always_comb begin
    if (cfg.spin_clockwise) begin
      diff = {1'b0, frame_head} + (LB+1)'(lrss_pkg::LED_COUNT) - {1'b0, pix_index};
    end else begin
      diff = {1'b0, pix_index} + (LB+1)'(lrss_pkg::LED_COUNT) - {1'b0, frame_head};
    end
    tail_k = (diff >= (LB+1)'(lrss_pkg::LED_COUNT)) ?
             LB'(diff - (LB+1)'(lrss_pkg::LED_COUNT)) : diff[LB-1:0];
    entry  = {1'b0, frame_first} + {1'b0, tail_k};
    lit    = (tail_k < frame_count) && (entry < (LB+1)'(lrss_pkg::LED_COUNT));
    pix_colour = lit ? tail_colors[entry[LB-1:0]] : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      led_index   <= pix_index;
      red_out     <= pix_colour[23:16];
      green_out   <= pix_colour[15:8];
      blue_out    <= pix_colour[7:0];
      hold_period <= frame_hold;
      frame_last  <= (pix_index == lrss_pkg::LED_LAST);
    end
  end

  assign status.frame_req = frame_req;
  assign status.out_valid = out_valid;
  assign status.pix_last  = (pix_index == lrss_pkg::LED_LAST);

endmodule

`default_nettype wire

// ===== rtl/led_ring_spinner_sequencer_top.sv =====
// A frame-producing transaction is taken into the frame setup registers, then its LED 0
// is rendered into the output register; the twelve LED results follow one per cycle, as
// the datapath renders one LED a cycle while the output is not stalled.
// Input stalls until a frame's last LED is rendered; other transactions do not stall it.
// Reset: synchronous, active high; resets config registers, comet state, tail colours.
`default_nettype none

module led_ring_spinner_sequencer_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [lrss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [lrss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          operation,
  input  wire logic                                end_now,
  input  wire logic [lrss_pkg::DEGREE_BITS-1:0]    target_angle,
  input  wire logic [lrss_pkg::LED_BITS-1:0]       color_index,
  input  wire logic [7:0]                          red_in,
  input  wire logic [7:0]                          green_in,
  input  wire logic [7:0]                          blue_in,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [lrss_pkg::LED_BITS-1:0]            led_index,
  output logic [7:0]                               red_out,
  output logic [7:0]                               green_out,
  output logic [7:0]                               blue_out,
  output logic [lrss_pkg::PERIOD_BITS-1:0]         hold_period,
  output logic                                     frame_last
);

  lrss_pkg::cfg_t       cfg;
  lrss_pkg::ctl_cmd_t   cmd;
  lrss_pkg::dp_status_t dp_status;

  lrss_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lrss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (dp_status),
    .cmd       (cmd)
  );

  lrss_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (dp_status),
    .operation    (operation),
    .end_now      (end_now),
    .target_angle (target_angle),
    .color_index  (color_index),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .led_index    (led_index),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .hold_period  (hold_period),
    .frame_last   (frame_last)
  );

`ifndef SYNTHESIS
  // A taken LED other than the last is followed at once by the next LED
  a_led_sequence: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !frame_last |=>
      out_valid && (led_index == $past(led_index) + 1'b1))
    else $error("LED results out of sequence within a frame");

  // Hold period is constant across a frame
  a_hold_constant: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !frame_last |=> (hold_period == $past(hold_period)))
    else $error("hold period changed inside a frame");

  // No transaction is taken while a frame is part way out
  a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_last |-> in_stall)
    else $error("input taken during frame emission");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_led_ring_spinner_sequencer_top.sv =====
// Self-checking testbench for the LED ring spinner sequencer: drives comet runs through
// the input channel and compares every rendered LED transaction with a predicted frame.
// Depends on rtl/lrss_pkg.sv and rtl/led_ring_spinner_sequencer_top.sv.
`timescale 1ns / 1ps

module tb_led_ring_spinner_sequencer_top;
  import lrss_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 14;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 3'd7;
  // Operation code the block does not know
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic [CFG_INDEX_BITS-1:0] REG_ORDER [7] = '{
    CFG_ORIGIN_ANGLE, CFG_SPIN_CLOCKWISE, CFG_TAIL_LENGTH, CFG_BASE_PERIOD,
    CFG_ACCEL_STEP, CFG_MIN_PERIOD, CFG_UNUSED
  };

  typedef struct {
    logic [LED_BITS-1:0]    led;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [PERIOD_BITS-1:0] hold;
    logic                   last;
  } led_result_t;

  // Comet predictor plus the queue of LED transactions still owed by the block
  class comet_frames;
    logic [DEGREE_BITS-1:0] start_deg;
    logic                   clockwise;
    logic [LED_BITS-1:0]    tail_len;
    logic [PERIOD_BITS-1:0] base_per;
    logic [STEP_BITS-1:0]   accel;
    logic [PERIOD_BITS-1:0] min_per;

    phase_t                 phase;
    logic [LED_BITS-1:0]    head;
    logic [LED_BITS-1:0]    drawn;
    logic [PERIOD_BITS-1:0] period;
    logic                   end_pend;
    logic                   end_at_head;
    logic [LED_BITS-1:0]    end_pos;
    logic [LED_BITS-1:0]    fade_cnt;
    logic [COLOUR_BITS-1:0] palette [LED_COUNT];
    logic [COLOUR_BITS-1:0] canvas [LED_COUNT];

    led_result_t            due_leds [$];
    int                     errors;

    function new();
      start_deg   = ORIGIN_ANGLE_RST;
      clockwise   = SPIN_CLOCKWISE_RST;
      tail_len    = TAIL_LENGTH_RST;
      base_per    = BASE_PERIOD_RST;
      accel       = ACCEL_STEP_RST;
      min_per     = MIN_PERIOD_RST;
      phase       = PH_IDLE;
      head        = '0;
      drawn       = '0;
      period      = '0;
      end_pend    = 1'b0;
      end_at_head = 1'b0;
      end_pos     = '0;
      fade_cnt    = '0;
      foreach (palette[i]) palette[i] = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_ORIGIN_ANGLE:   start_deg = data[DEGREE_BITS-1:0];
        CFG_SPIN_CLOCKWISE: clockwise = data[0];
        CFG_TAIL_LENGTH:    tail_len  = data[LED_BITS-1:0];
        CFG_BASE_PERIOD:    base_per  = data[PERIOD_BITS-1:0];
        CFG_ACCEL_STEP:     accel     = data[STEP_BITS-1:0];
        CFG_MIN_PERIOD:     min_per   = data[PERIOD_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [LED_BITS-1:0] ring_pos(logic [DEGREE_BITS-1:0] deg);
      return LED_BITS'((int'(deg) / DEGREES_PER_LED) % LED_COUNT);
    endfunction

    function logic [LED_BITS-1:0] next_pos(logic [LED_BITS-1:0] pos, logic up);
      int p;
      p = up ? int'(pos) + 1 : int'(pos) + LED_COUNT - 1;
      return LED_BITS'(p % LED_COUNT);
    endfunction

    // Tail lengths above the ring size light the whole ring
    function int lit_len();
      return (tail_len > LED_COUNT) ? LED_COUNT : int'(tail_len);
    endfunction

    // Lay count tail entries from entry first behind the anchor LED
    function void paint(int anchor, int count, int first);
      int led;
      for (int k = 0; k < count && first + k < LED_COUNT; k++) begin
        led = clockwise ? (anchor + LED_COUNT - k) % LED_COUNT : (anchor + k) % LED_COUNT;
        canvas[led] = palette[first + k];
      end
    endfunction

    function void push_frame(logic [PERIOD_BITS-1:0] hold);
      led_result_t r;
      for (int i = 0; i < LED_COUNT; i++) begin
        r.led   = LED_BITS'(i);
        r.red   = canvas[i][23:16];
        r.green = canvas[i][15:8];
        r.blue  = canvas[i][7:0];
        r.hold  = hold;
        r.last  = (i == LED_COUNT - 1);
        due_leds.push_back(r);
      end
    endfunction

    // Draw the comet, then move the head on and let the tail grow
    function void moving_frame();
      paint(head, drawn, 0);
      head = next_pos(head, clockwise);
      if (drawn < lit_len()) drawn++;
    endfunction

    function void tick();
      logic [PERIOD_BITS-1:0] hold;
      int len;
      foreach (canvas[i]) canvas[i] = '0;
      if (phase == PH_SPIN) begin
        if (!end_pend) begin
          moving_frame();
          hold = period;
          if (period >= min_per) begin
            period = (period >= PERIOD_BITS'(accel)) ? period - PERIOD_BITS'(accel) : '0;
          end
          push_frame(hold);
          return;
        end
        if (end_at_head) end_pos = head;
        end_pend = 1'b0;
        phase    = PH_SEEK;
      end
      if (phase == PH_SEEK) begin
        if (head != end_pos) begin
          moving_frame();
          push_frame(base_per);
          return;
        end
        phase    = PH_FADE;
        fade_cnt = '0;
      end
      if (phase == PH_FADE) begin
        len = lit_len();
        if (fade_cnt >= len) begin
          phase = PH_IDLE;
          return;
        end
        // fade is anchored on the last LED the head was drawn at
        paint(next_pos(head, !clockwise), len - int'(fade_cnt) - 1, int'(fade_cnt) + 1);
        fade_cnt++;
        if (fade_cnt >= len) phase = PH_IDLE;
        push_frame(base_per);
      end
    endfunction

    // Note an accepted input transaction and queue the LEDs it must produce
    function void take(logic [2:0] op, logic now, logic [DEGREE_BITS-1:0] deg,
                       logic [LED_BITS-1:0] idx, logic [7:0] r, logic [7:0] g,
                       logic [7:0] b);
      case (op)
        OP_TICK: tick();
        OP_START: begin
          phase       = PH_SPIN;
          head        = ring_pos(start_deg);
          drawn       = '0;
          period      = base_per;
          end_pend    = 1'b0;
          end_at_head = 1'b0;
          fade_cnt    = '0;
        end
        OP_END: begin
          if (phase == PH_SPIN) begin
            end_pend    = 1'b1;
            end_at_head = now;
            end_pos     = ring_pos(deg);
          end
        end
        OP_STOP: begin
          phase    = PH_IDLE;
          end_pend = 1'b0;
          foreach (canvas[i]) canvas[i] = '0;
          push_frame('0);
        end
        OP_LOAD: begin
          if (idx < LED_COUNT) palette[idx] = {r, g, b};
        end
        default: ;
      endcase
    endfunction

    function void diff(string fld, logic [PERIOD_BITS-1:0] want, logic [PERIOD_BITS-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
        errors++;
      end
    endfunction

    // Compare one output transaction with the oldest owed LED
    function void check(led_result_t got);
      led_result_t want;
      if (due_leds.size() == 0) begin
        $display("%0t: unexpected LED transaction, expected none, actual led %0d",
                 $time, got.led);
        errors++;
        return;
      end
      want = due_leds.pop_front();
      diff("led_index", want.led, got.led);
      diff("red_out", want.red, got.red);
      diff("green_out", want.green, got.green);
      diff("blue_out", want.blue, got.blue);
      diff("hold_period", want.hold, got.hold);
      diff("frame_last", want.last, got.last);
    endfunction

    function void flush();
      if (due_leds.size() != 0) begin
        $display("%0t: LED transactions missing, expected %0d more, actual 0",
                 $time, due_leds.size());
        errors++;
      end
    endfunction
  endclass

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_we       = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic [2:0]                operation    = '0;
  logic                      end_now      = 1'b0;
  logic [DEGREE_BITS-1:0]    target_angle = '0;
  logic [LED_BITS-1:0]       color_index  = '0;
  logic [7:0]                red_in       = '0;
  logic [7:0]                green_in     = '0;
  logic [7:0]                blue_in      = '0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic [LED_BITS-1:0]       led_index;
  logic [7:0]                red_out;
  logic [7:0]                green_out;
  logic [7:0]                blue_out;
  logic [PERIOD_BITS-1:0]    hold_period;
  logic                      frame_last;

  comet_frames               board;
  led_result_t               seen;
  int                        items_sent = 0;
  logic                      calm       = 1'b0;

  led_ring_spinner_sequencer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .end_now      (end_now),
    .target_angle (target_angle),
    .color_index  (color_index),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .led_index    (led_index),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .hold_period  (hold_period),
    .frame_last   (frame_last)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Output transactions are checked as they are accepted
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.led   = led_index;
      seen.red   = red_out;
      seen.green = green_out;
      seen.blue  = blue_out;
      seen.hold  = hold_period;
      seen.last  = frame_last;
      board.check(seen);
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transaction means the block has hung
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  // Present one input transaction, hold it until taken, then predict its effect
  task automatic send_item(input logic [2:0] op, input logic now,
                           input logic [DEGREE_BITS-1:0] deg, input logic [LED_BITS-1:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    operation    <= op;
    end_now      <= now;
    target_angle <= deg;
    color_index  <= idx;
    red_in       <= r;
    green_in     <= g;
    blue_in      <= b;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.take(op, now, deg, idx, r, g, b);
    items_sent++;
  endtask

  task automatic send_op(input logic [2:0] op);
    send_item(op, 1'($urandom), DEGREE_BITS'($urandom), LED_BITS'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Let every owed LED arrive, then give the block time to finish silent work
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the whole register set, plus the unused index, back to back
  task automatic apply_settings(input int p);
    logic [CFG_DATA_BITS-1:0] vals [7];
    case (p)
      1: vals = '{20'd359, 20'd0, 20'd12, 20'hFFFFF, 20'hFFFF, 20'd0, 20'hFFFFF};
      2: vals = '{20'd0, 20'd1, 20'd0, 20'd0, 20'd0, 20'hFFFFF, 20'd0};
      // stray upper bits: start 511, counter-clockwise, tail 15
      3: vals = '{20'hFFFFF, 20'hFFFFE, 20'hFFFFF, 20'd3000, 20'd700, 20'd1000, 20'h55555};
      4: begin
        foreach (vals[i]) vals[i] = CFG_DATA_BITS'($urandom);
      end
      default: begin
        vals[0] = CFG_DATA_BITS'($urandom_range(0, 359));
        vals[1] = CFG_DATA_BITS'($urandom_range(0, 1));
        vals[2] = CFG_DATA_BITS'($urandom_range(1, 12));
        vals[3] = CFG_DATA_BITS'($urandom_range(2000, 6000));
        vals[4] = CFG_DATA_BITS'($urandom_range(1, 600));
        vals[5] = CFG_DATA_BITS'($urandom_range(0, 3000));
        vals[6] = CFG_DATA_BITS'($urandom);
      end
    endcase
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      board.write_reg(REG_ORDER[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // One comet from start through spin, end request, seek and fade
  task automatic run_comet();
    int guard;
    repeat ($urandom_range(0, 3)) begin
      send_item(OP_LOAD, 1'($urandom), DEGREE_BITS'($urandom),
                LED_BITS'($urandom_range(0, LED_COUNT - 1)),
                8'($urandom), 8'($urandom), 8'($urandom));
    end
    send_op(OP_START);
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 7) == 0) begin
        send_op(OP_LOAD);
      end else begin
        send_op(OP_TICK);
      end
    end
    send_op(OP_END);
    // a second request before the tick replaces the first
    if ($urandom_range(0, 3) == 0) send_op(OP_END);
    guard = 0;
    while (board.phase != PH_IDLE && guard < 40) begin
      case ($urandom_range(0, 24))
        0: send_op(OP_STOP);
        1: send_op(OP_LOAD);
        2: begin
          send_op(OP_START);
          send_op(OP_END);
        end
        default: send_op(OP_TICK);
      endcase
      guard++;
    end
  endtask

  initial begin
    int phase_start;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: palette, ignored transactions, a short comet ending at its head
    for (int i = 0; i < LED_COUNT; i++) begin
      send_item(OP_LOAD, 1'b0, '0, LED_BITS'(i), (i == 0) ? 8'hFF : 8'(i * 21),
                (i == 0) ? 8'hFF : 8'(255 - i * 19), (i == 0) ? 8'hFF : 8'(i * 37));
    end
    send_item(OP_LOAD, 1'b1, '1, 4'hF, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_TICK, 1'b0, '0, '0, '0, '0, '0);
    send_item(OP_END, 1'b1, 9'd0, '0, '0, '0, '0);
    send_item(OP_UNUSED, 1'b1, '1, '1, '1, '1, '1);
    send_item(OP_START, 1'b0, '0, '0, '0, '0, '0);
    repeat (3) send_item(OP_TICK, 1'b0, '0, '0, '0, '0, '0);
    send_item(OP_END, 1'b1, 9'd359, '0, '0, '0, '0);
    // head is at LED 3 now, so this target skips the seek and goes straight to fade
    send_item(OP_END, 1'b0, 9'd119, '0, '0, '0, '0);
    repeat (2) send_item(OP_TICK, 1'b0, '0, '0, '0, '0, '0);
    send_item(OP_STOP, 1'b0, '0, '0, '0, '0, '0);
    send_item(OP_TICK, 1'b0, '0, '0, '0, '0, '0);

    // Random: comet runs mixed with noise under several register settings
    for (int p = 1; p <= PHASES; p++) begin
      settle();
      apply_settings(p);
      if (p == PHASES) calm = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          run_comet();
        end else begin
          repeat ($urandom_range(1, 4)) send_op(3'($urandom));
        end
      end
    end

    settle();
    board.flush();
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== led_ring_spinner_sequencer_top.f =====
rtl/lrss_pkg.sv
rtl/lrss_cfg_regs.sv
rtl/lrss_ctrl.sv
rtl/lrss_datapath.sv
rtl/led_ring_spinner_sequencer_top.sv
sim/tb_led_ring_spinner_sequencer_top.sv
